// File: rtl/core/mcsph_pkg.sv
// Package for the channel selector with peak hold.
// Types, codes and constants shared by mcsph_ctrl, mcsph_dp and the top level.
// No dependencies.
package mcsph_pkg;

    // Reading format default and channel counts
    localparam int READING_BITS_DEF = 16;
    localparam int NCHAN            = 6;
    localparam int CH_W             = 3;
    localparam int IN_W             = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int THR_W      = 16;
    localparam int OFS_W      = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MIN_POT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MIN_ADC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET_A  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET_B  = 3'd4;

    // Register reset values: 0.008, 0.30 and 0.02 of full scale, offsets of 1.0
    localparam logic [THR_W-1:0] MOVE_THRESHOLD_RST = 16'd524;
    localparam logic [THR_W-1:0] GAIN_MIN_POT_RST   = 16'd19661;
    localparam logic [THR_W-1:0] GAIN_MIN_ADC_RST   = 16'd1311;
    localparam logic [OFS_W-1:0] ZERO_OFFSET_RST    = 17'd65536;

    // Channel selection codes
    localparam logic [CH_W-1:0] SEL_POT_BANK = 3'd2;
    localparam logic [CH_W-1:0] SEL_SUM_BANK = 3'd4;

    // Displayed value and digits
    localparam int VAL_W     = 10;
    localparam int DIG_W     = 4;
    localparam int POT_SCALE = 1000;
    localparam logic [VAL_W-1:0] VAL_MAX = 10'd999;

    // Serial divider: one quotient bit per step, top bit flags overflow
    localparam int DIV_STEPS = 11;
    localparam int CNT_W     = 4;

    typedef enum logic [1:0] {
        VIEW_LIVE = 2'd0,
        VIEW_MIN  = 2'd1,
        VIEW_MAX  = 2'd2
    } t_view;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_FETCH_A,
        S_FETCH_B,
        S_MUL,
        S_DIV,
        S_GVAL,
        S_POTV,
        S_DIGH,
        S_DIGT
    } t_state;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_TAKE,
        OP_SCAN,
        OP_PICK,
        OP_FETCH_A,
        OP_FETCH_B,
        OP_MUL,
        OP_DIV,
        OP_GVAL,
        OP_POTV,
        OP_DIGH,
        OP_DIGT
    } t_op;

    // Command from controller to datapath
    typedef struct packed {
        t_op             op;
        logic [CH_W-1:0] chan;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic frame;
        logic primed;
        logic is_gain;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/core/mcsph_ctrl.sv
// Controller state machine for the channel selector with peak hold.
// Sequences the channel scan, operand fetch, serial divide and digit split.
// Depends on mcsph_pkg.
module mcsph_ctrl
    import mcsph_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             take;

    assign take = i_in_valid && (r_state == S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take && i_stat.frame && i_stat.primed) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_cnt == CNT_W'(NCHAN - 1)) n_state = S_PICK;
            end
            S_PICK:    n_state = S_FETCH_A;
            S_FETCH_A: n_state = i_stat.is_gain ? S_FETCH_B : S_POTV;
            S_FETCH_B: n_state = S_MUL;
            S_MUL:     n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_GVAL;
            end
            S_GVAL:    n_state = S_DIGH;
            S_POTV:    n_state = S_DIGH;
            S_DIGH:    n_state = S_DIGT;
            S_DIGT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Step counter: advance only inside the scan and the divide
    always_comb begin
        if ((n_state == r_state) && ((r_state == S_SCAN) || (r_state == S_DIV))) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else begin
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Outputs: command per state
    always_comb begin
        o_cmd.chan = r_cnt[CH_W-1:0];
        o_cmd.op   = OP_IDLE;
        unique case (r_state)
            S_IDLE:    o_cmd.op = take ? OP_TAKE : OP_IDLE;
            S_SCAN:    o_cmd.op = OP_SCAN;
            S_PICK:    o_cmd.op = OP_PICK;
            S_FETCH_A: o_cmd.op = OP_FETCH_A;
            S_FETCH_B: o_cmd.op = OP_FETCH_B;
            S_MUL:     o_cmd.op = OP_MUL;
            S_DIV:     o_cmd.op = OP_DIV;
            S_GVAL:    o_cmd.op = OP_GVAL;
            S_POTV:    o_cmd.op = OP_POTV;
            S_DIGH:    o_cmd.op = OP_DIGH;
            S_DIGT:    o_cmd.op = i_stat.out_free ? OP_DIGT : OP_IDLE;
            default:   o_cmd.op = OP_IDLE;
        endcase
        o_in_stall = (r_state != S_IDLE);
    end

endmodule

// File: rtl/core/mcsph_dp.sv
// Datapath for the channel selector with peak hold.
// Holds readings, peaks, selection, config registers, divider and output register.
// Depends on mcsph_pkg.
module mcsph_dp
    import mcsph_pkg::*;
#(
    parameter int READING_BITS = READING_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_command,
    input  logic [IN_W-1:0]       i_pot_a,
    input  logic [IN_W-1:0]       i_pot_b,
    input  logic [IN_W-1:0]       i_pot_rate,
    input  logic [IN_W-1:0]       i_pot_tone,
    input  logic [IN_W-1:0]       i_sum_a,
    input  logic [IN_W-1:0]       i_sum_b,
    input  logic                  i_cv_bank,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [CH_W-1:0]       o_letter_index,
    output logic [DIG_W-1:0]      o_digit_hundreds,
    output logic [DIG_W-1:0]      o_digit_tens,
    output logic [DIG_W-1:0]      o_digit_units,
    output logic                  o_dot_on_letter,
    output logic                  o_dot_on_units,
    output logic                  o_show_dashes
);

    localparam int RB = READING_BITS;
    localparam int TW = RB + 16;   // threshold compare width
    localparam int NW = RB + 17;   // gain numerator width
    localparam int DW = RB + 27;   // divisor shifted to the top quotient bit
    localparam int RW = RB + 29;   // dividend after scaling

    // Config registers
    logic [THR_W-1:0] r_move_thr, r_gmin_pot, r_gmin_adc;
    logic [OFS_W-1:0] r_ofs_a, r_ofs_b;

    // Channel stores
    logic [RB-1:0] r_rd   [NCHAN];
    logic [RB-1:0] r_last [NCHAN];
    logic [RB-1:0] r_min  [NCHAN];
    logic [RB-1:0] r_max  [NCHAN];
    logic [RB-1:0] rd_in  [NCHAN];

    // Control state
    logic            r_primed, r_bank;
    logic [CH_W-1:0] r_sel, r_moved;
    logic            r_mv_valid;
    t_view           r_view;

    // Working registers
    logic [TW-1:0]        r_best;
    logic [RB-1:0]        r_opa;
    logic [RW-1:0]        r_rem;
    logic [DW-1:0]        r_div;
    logic [DIV_STEPS-1:0] r_q;
    logic                 r_dash, r_zero, r_dl, r_du;
    logic [VAL_W-1:0]     r_val;
    logic [DIG_W-1:0]     r_hund;

    // Output register
    logic                 r_out_valid;
    logic [CH_W-1:0]      r_out_letter;
    logic [DIG_W-1:0]     r_out_hund, r_out_tens, r_out_units;
    logic                 r_out_dl, r_out_du, r_out_dash;

    // Combinational helpers
    logic [CH_W-1:0]  rd_addr;
    logic [RB-1:0]    rd_q, last_q, min_q, max_q, view_q;
    logic [RB-1:0]    delta;
    logic [TW-1:0]    delta16;
    logic             in_bank;
    logic             is_gain;
    logic [OFS_W-1:0] ofs_sel;
    logic [NW-1:0]    g_num, g_sub;
    logic             g_dash;
    logic [RW-1:0]    scaled;
    logic             div_ge;
    logic [RB+9:0]    pv_prod;
    logic [VAL_W-1:0] pv_val, gv_val;
    logic [DIG_W-1:0] hund, tens;
    logic [VAL_W-1:0] hsub, tsub, units_full;
    logic             out_free;
    logic             take_frame;

    assign rd_in[0] = RB'(i_pot_a);
    assign rd_in[1] = RB'(i_pot_b);
    assign rd_in[2] = RB'(i_pot_rate);
    assign rd_in[3] = RB'(i_pot_tone);
    assign rd_in[4] = RB'(i_sum_a);
    assign rd_in[5] = RB'(i_sum_b);

    assign is_gain    = r_sel[2];
    assign out_free   = !r_out_valid || !i_out_stall;
    assign take_frame = (i_cmd.op == OP_TAKE) && i_command;

    assign o_stat.frame    = i_command;
    assign o_stat.primed   = r_primed;
    assign o_stat.is_gain  = is_gain;
    assign o_stat.out_free = out_free;

    // Store read address: scan channel, displayed pot, or gain operands
    always_comb begin
        unique case (i_cmd.op)
            OP_SCAN:    rd_addr = i_cmd.chan;
            OP_FETCH_A: rd_addr = is_gain ? {2'b00, r_sel[0]} : r_sel;
            OP_FETCH_B: rd_addr = {2'b10, r_sel[0]};
            default:    rd_addr = i_cmd.chan;
        endcase
    end

    assign rd_q   = r_rd[rd_addr];
    assign last_q = r_last[rd_addr];
    assign min_q  = r_min[rd_addr];
    assign max_q  = r_max[rd_addr];

    // Movement of the scanned channel against the best so far
    always_comb begin
        delta   = (rd_q >= last_q) ? (rd_q - last_q) : (last_q - rd_q);
        delta16 = {delta, 16'b0};
        in_bank = r_bank ? (rd_addr >= SEL_SUM_BANK) : (rd_addr < SEL_SUM_BANK);
    end

    // Pot view select
    always_comb begin
        unique case (r_view)
            VIEW_MIN: view_q = min_q;
            VIEW_MAX: view_q = max_q;
            default:  view_q = rd_q;
        endcase
    end

    // Gain checks and numerator, aligned by cross-shifting
    always_comb begin
        ofs_sel = r_sel[0] ? r_ofs_b : r_ofs_a;
        g_num   = {ofs_sel, {RB{1'b0}}};
        g_sub   = {1'b0, rd_q, 16'b0};
        g_dash  = (r_opa == '0)
               || ({r_opa, 16'b0} < {r_gmin_pot, {RB{1'b0}}})
               || ({rd_q, 16'b0} < {r_gmin_adc, {RB{1'b0}}});
    end

    // Scale by 2000 as 2048 - 32 - 16, add the rounding half divisor
    assign scaled = (r_rem << 11) - (r_rem << 5) - (r_rem << 4)
                  + RW'({r_opa, 16'b0});

    assign div_ge = (r_rem >= {2'b00, r_div});

    // Pot value: round r * 1000 and clamp
    always_comb begin
        pv_prod = (RB + 10)'(r_opa) * (RB + 10)'(POT_SCALE)
                + (RB + 10)'({1'b1, {(RB - 1){1'b0}}});
        pv_val  = pv_prod[RB+9:RB];
        if (pv_val > VAL_MAX) pv_val = VAL_MAX;
    end

    // Gain value: clamp quotient, zero on dashes or nonpositive numerator
    always_comb begin
        if (r_dash || r_zero) begin
            gv_val = '0;
        end else if (r_q[DIV_STEPS-1] || (r_q[VAL_W-1:0] > VAL_MAX)) begin
            gv_val = VAL_MAX;
        end else begin
            gv_val = r_q[VAL_W-1:0];
        end
    end

    // Digit split by constant compares
    always_comb begin
        hund = '0;
        hsub = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r_val >= VAL_W'(100 * k)) begin
                hund = DIG_W'(k);
                hsub = VAL_W'(100 * k);
            end
        end
        tens = '0;
        tsub = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r_val >= VAL_W'(10 * k)) begin
                tens = DIG_W'(k);
                tsub = VAL_W'(10 * k);
            end
        end
        units_full = r_val - tsub;
    end

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_thr <= MOVE_THRESHOLD_RST;
            r_gmin_pot <= GAIN_MIN_POT_RST;
            r_gmin_adc <= GAIN_MIN_ADC_RST;
            r_ofs_a    <= ZERO_OFFSET_RST;
            r_ofs_b    <= ZERO_OFFSET_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MOVE_THRESHOLD: r_move_thr <= i_cfg_data[THR_W-1:0];
                CFG_GAIN_MIN_POT:   r_gmin_pot <= i_cfg_data[THR_W-1:0];
                CFG_GAIN_MIN_ADC:   r_gmin_adc <= i_cfg_data[THR_W-1:0];
                CFG_ZERO_OFFSET_A:  r_ofs_a    <= i_cfg_data[OFS_W-1:0];
                CFG_ZERO_OFFSET_B:  r_ofs_b    <= i_cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // Channel stores: capture on a frame, prime all, update one channel per scan step
    always_ff @(posedge i_clk) begin
        if (take_frame) begin
            for (int i = 0; i < NCHAN; i++) begin
                r_rd[i] <= rd_in[i];
                if (!r_primed) begin
                    r_last[i] <= rd_in[i];
                    r_min[i]  <= rd_in[i];
                    r_max[i]  <= rd_in[i];
                end
            end
        end else if (i_cmd.op == OP_SCAN) begin
            if (rd_q < min_q) r_min[rd_addr] <= rd_q;
            if (rd_q > max_q) r_max[rd_addr] <= rd_q;
            r_last[rd_addr] <= rd_q;
        end
    end

    // Control state: priming, bank, view, selection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed   <= 1'b0;
            r_bank     <= 1'b0;
            r_view     <= VIEW_LIVE;
            r_sel      <= SEL_POT_BANK;
            r_mv_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_TAKE: begin
                    if (!i_command) begin
                        unique case (r_view)
                            VIEW_LIVE: r_view <= VIEW_MIN;
                            VIEW_MIN:  r_view <= VIEW_MAX;
                            default:   r_view <= VIEW_LIVE;
                        endcase
                    end else if (!r_primed) begin
                        r_primed <= 1'b1;
                        r_bank   <= i_cv_bank;
                    end else begin
                        if (i_cv_bank != r_bank) begin
                            r_sel <= i_cv_bank ? SEL_SUM_BANK : SEL_POT_BANK;
                        end
                        r_bank     <= i_cv_bank;
                        r_mv_valid <= 1'b0;
                    end
                end
                OP_SCAN: begin
                    if (in_bank && (delta16 > r_best)) r_mv_valid <= 1'b1;
                end
                OP_PICK: begin
                    if (r_mv_valid) r_sel <= r_moved;
                end
                default: ;
            endcase
        end
    end

    // Working registers: best move, operands, divider, value
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_TAKE: begin
                r_best <= {r_move_thr, {RB{1'b0}}};
            end
            OP_SCAN: begin
                if (in_bank && (delta16 > r_best)) begin
                    r_best  <= delta16;
                    r_moved <= rd_addr;
                end
            end
            OP_FETCH_A: begin
                if (is_gain) begin
                    r_opa <= rd_q;
                    r_dl  <= 1'b0;
                    r_du  <= 1'b0;
                end else begin
                    r_opa  <= view_q;
                    r_dl   <= (r_view == VIEW_MIN);
                    r_du   <= (r_view == VIEW_MAX);
                    r_dash <= 1'b0;
                end
            end
            OP_FETCH_B: begin
                r_dash <= g_dash;
                r_zero <= (g_num <= g_sub);
                r_rem  <= RW'(g_num - g_sub);
            end
            OP_MUL: begin
                r_rem <= scaled;
                r_div <= {r_opa, 27'b0};
                r_q   <= '0;
            end
            OP_DIV: begin
                if (div_ge) r_rem <= r_rem - {2'b00, r_div};
                r_q   <= {r_q[DIV_STEPS-2:0], div_ge};
                r_div <= r_div >> 1;
            end
            OP_GVAL: r_val <= gv_val;
            OP_POTV: r_val <= pv_val;
            OP_DIGH: begin
                r_hund <= hund;
                r_val  <= r_val - hsub;
            end
            default: ;
        endcase
    end

    // Output register: load on the last digit step, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_DIGT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_DIGT) begin
            r_out_letter <= r_sel;
            r_out_hund   <= r_hund;
            r_out_tens   <= tens;
            r_out_units  <= units_full[DIG_W-1:0];
            r_out_dl     <= r_dl;
            r_out_du     <= r_du;
            r_out_dash   <= r_dash;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_letter_index   = r_out_letter;
    assign o_digit_hundreds = r_out_hund;
    assign o_digit_tens     = r_out_tens;
    assign o_digit_units    = r_out_units;
    assign o_dot_on_letter  = r_out_dl;
    assign o_dot_on_units   = r_out_du;
    assign o_show_dashes    = r_out_dash;

endmodule

// File: rtl/core/moved_channel_selector_peak_hold.sv
// Top level of the channel selector with peak hold.
// Joins the controller mcsph_ctrl and the datapath mcsph_dp; depends on mcsph_pkg.
//
// A click advances the view (live, minimum, maximum) and gives no result. A
// frame is taken only while the block is idle; the first frame after reset
// only loads the history. Each later frame gives one result: the six
// channels are scanned one per cycle for peaks and movement, then a pot
// channel is fetched and scaled, while a summed channel also passes through
// a multiply and an 11-step bit-serial divider for its gain. The input
// stalls until the block is idle again. A finished result waits in an output
// register, and the next item may be taken meanwhile; the block holds its
// last step until that register is free. Configuration writes are always ready.
module moved_channel_selector_peak_hold
    import mcsph_pkg::*;
#(
    parameter int READING_BITS = READING_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic [IN_W-1:0]       i_pot_a,
    input  logic [IN_W-1:0]       i_pot_b,
    input  logic [IN_W-1:0]       i_pot_rate,
    input  logic [IN_W-1:0]       i_pot_tone,
    input  logic [IN_W-1:0]       i_sum_a,
    input  logic [IN_W-1:0]       i_sum_b,
    input  logic                  i_cv_bank,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CH_W-1:0]       o_letter_index,
    output logic [DIG_W-1:0]      o_digit_hundreds,
    output logic [DIG_W-1:0]      o_digit_tens,
    output logic [DIG_W-1:0]      o_digit_units,
    output logic                  o_dot_on_letter,
    output logic                  o_dot_on_units,
    output logic                  o_show_dashes
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    mcsph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Datapath
    mcsph_dp #(
        .READING_BITS (READING_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_pot_a          (i_pot_a),
        .i_pot_b          (i_pot_b),
        .i_pot_rate       (i_pot_rate),
        .i_pot_tone       (i_pot_tone),
        .i_sum_a          (i_sum_a),
        .i_sum_b          (i_sum_b),
        .i_cv_bank        (i_cv_bank),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_letter_index   (o_letter_index),
        .o_digit_hundreds (o_digit_hundreds),
        .o_digit_tens     (o_digit_tens),
        .o_digit_units    (o_digit_units),
        .o_dot_on_letter  (o_dot_on_letter),
        .o_dot_on_units   (o_dot_on_units),
        .o_show_dashes    (o_show_dashes)
    );

endmodule
